// ===== rtl/bbci_pkg.sv =====
// package: shared constants, codes, types and structs for the boundary color index block
`timescale 1ns / 1ps
`default_nettype none

package bbci_pkg;

  localparam int BBCI_MAX_BOUNDARIES = 16;

  localparam int VAL_W      = 32;
  localparam int SLOT_W     = 4;
  localparam int BCNT_W     = 5;
  localparam int CCNT_W     = 9;
  localparam int RCNT_W     = 5;
  localparam int CI_W       = 10;
  localparam int NORM_W     = 19;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // shared divider: numerator covers |index| << 16, denominator covers colors - 1
  localparam int DIV_NW    = 26;
  localparam int DIV_DW    = 9;
  localparam int DIV_STEPS = 2;
  localparam int DIV_CYC   = DIV_NW / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOUNDARY_COUNT = 3'd0,
    REG_COLOR_COUNT    = 3'd1,
    REG_REGION_COUNT   = 3'd2,
    REG_INDEX_OFFSET   = 3'd3,
    REG_CLIP_ENABLE    = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    REQ_WRITE    = 1'b0,
    REQ_CLASSIFY = 1'b1
  } req_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_HI,
    S_CLAMP,
    S_SCAN,
    S_INDEX,
    S_STRETCH,
    S_DIV_WAIT1,
    S_LIMIT,
    S_NORM,
    S_DIV_WAIT2,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bbci_if.sv =====
// interfaces: request channel and result channel with valid/ready handshake
`timescale 1ns / 1ps
`default_nettype none

interface bbci_req_if
  import bbci_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [SLOT_W-1:0]        slot;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output req_type, output slot, output value, input ready);
  modport sink   (input valid, input req_type, input slot, input value, output ready);
endinterface

interface bbci_res_if
  import bbci_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [CI_W-1:0]   color_index;
  logic signed [NORM_W-1:0] normalized;

  modport source (output valid, output color_index, output normalized, input ready);
  modport sink   (input valid, input color_index, input normalized, output ready);
endinterface

`default_nettype wire

// ===== rtl/bbci_table_mem.sv =====
// boundary table: single write port, single read port, registered read data
`timescale 1ns / 1ps
`default_nettype none

module bbci_table_mem
  import bbci_pkg::*;
#(
  parameter int DEPTH = BBCI_MAX_BOUNDARIES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [VAL_W-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bbci_divider.sv =====
// shared unsigned restoring divider, two quotient bits per cycle
`timescale 1ns / 1ps
`default_nettype none

module bbci_divider
  import bbci_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DW-1:0]    den_q;
  logic [DIV_DW-1:0]    rem;
  logic [DIV_NW-1:0]    quo;
  logic [DIV_DW-1:0]    rem_next;
  logic [DIV_NW-1:0]    quo_next;
  logic [DIV_DW-1:0]    r;
  logic [DIV_NW-1:0]    q;
  logic [DIV_DW:0]      sh;
  logic                 ge;

  // quo shifts numerator bits out at the top and quotient bits in at the bottom
  always_comb begin
    r  = rem;
    q  = quo;
    sh = '0;
    ge = 1'b0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      sh = {r, q[DIV_NW-1]};
      ge = (sh >= {1'b0, den_q});
      if (ge) begin
        r = DIV_DW'(sh - {1'b0, den_q});
      end else begin
        r = sh[DIV_DW-1:0];
      end
      q = {q[DIV_NW-2:0], ge};
    end
    rem_next = r;
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt   <= DIV_CNT_W'(DIV_CYC);
      rem   <= '0;
      quo   <= req.num;
      den_q <= req.den;
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

`default_nettype wire

// ===== rtl/boundary_bin_color_index.sv =====
// top level: boundary table color index with sequencer, table memory and shared divider
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type, slot, value (signed Q16.16)
//  res      out  valid/ready    color_index (signed 10b), normalized (signed Q2.16)
//  cfg      in   cfg_we         cfg_index, cfg_data (write only)
//
// a write item is done at the transfer edge, where the table write happens
// a classify item (nb = boundaries in use) makes two reads for the first and last
// boundary, then one table read per boundary for the count, then up to two divider
// passes, the stretch division only where it applies, that hold the sequencer until
// the quotient is done; with fewer than two boundaries or colors the sequencer goes
// from the transfer straight to the done state, and the result register loads from
// there once it is free
// synchronous active-high reset clears the configuration registers, the output valid,
// the divider state and the sequencer; the table holds no valid bits and is undefined until written
// a result waits in the output register while the next item is taken

`timescale 1ns / 1ps
`default_nettype none

module boundary_bin_color_index
  import bbci_pkg::*;
#(
  parameter int MAX_BOUNDARIES = BBCI_MAX_BOUNDARIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  bbci_req_if.sink                   req,
  bbci_res_if.source                 res,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_BOUNDARIES);
  localparam int CW = $clog2(MAX_BOUNDARIES + 1);

  // configuration registers
  logic [BCNT_W-1:0] boundary_count;
  logic [CCNT_W-1:0] color_count;
  logic [RCNT_W-1:0] region_count;
  logic              index_offset;
  logic              clip_enable;

  // sequencer and datapath
  seq_state_t              state;
  seq_state_t              state_next;
  logic signed [VAL_W-1:0] sample;
  logic signed [VAL_W-1:0] lo;
  logic signed [VAL_W-1:0] hi;
  logic signed [VAL_W-1:0] vc;
  logic signed [VAL_W-1:0] vc_next;
  logic [CW-1:0]           ptr;
  logic [CW-1:0]           cnt;
  logic signed [CI_W-1:0]  idx;
  logic [CI_W-1:0]         idx_abs;
  logic                    neg;
  logic signed [CI_W-1:0]  res_ci;
  logic signed [NORM_W-1:0] res_norm;
  logic [NORM_W-1:0]       quo_low;

  // output register
  logic                     out_valid;
  logic signed [CI_W-1:0]   out_ci;
  logic signed [NORM_W-1:0] out_norm;
  logic                     out_free;

  // derived
  logic [CW-1:0]     nb;
  logic [CCNT_W-1:0] ncol_m1;
  logic              trivial;
  logic              stretch_div;
  logic              single_region;
  logic              slot_ok;
  logic              in_xfer;
  logic              mem_we;
  logic [AW-1:0]     rd_addr;
  logic [VAL_W-1:0]  rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // boundary count saturates at the table depth
  assign nb = (32'(boundary_count) > MAX_BOUNDARIES) ? CW'(MAX_BOUNDARIES) : CW'(boundary_count);
  assign ncol_m1 = color_count - CCNT_W'(1);
  assign trivial = (nb < CW'(2)) || (color_count < CCNT_W'(2));

  // stretch only applies for more colors than regions; one region maps index 0 to mid color
  assign stretch_div   = (color_count > CCNT_W'(region_count)) && (region_count > RCNT_W'(1))
                         && !idx[CI_W-1];
  assign single_region = (color_count > CCNT_W'(region_count)) && (region_count == RCNT_W'(1))
                         && (idx == '0);

  assign slot_ok  = 32'(req.slot) < MAX_BOUNDARIES;
  assign in_xfer  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign idx_abs = idx[CI_W-1] ? CI_W'(-idx) : CI_W'(idx);
  assign quo_low = div_rsp.quo[NORM_W-1:0];

  // clamp against first and last boundary, first test wins
  always_comb begin
    vc_next = sample;
    if (clip_enable) begin
      if (sample < lo) begin
        vc_next = lo;
      end else if (sample > $signed(rdata)) begin
        vc_next = $signed(rdata);
      end
    end
  end

  // configuration writes, unknown register indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_count <= '0;
      color_count    <= '0;
      region_count   <= '0;
      index_offset   <= 1'b0;
      clip_enable    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BOUNDARY_COUNT: boundary_count <= cfg_data[BCNT_W-1:0];
        REG_COLOR_COUNT:    color_count    <= cfg_data[CCNT_W-1:0];
        REG_REGION_COUNT:   region_count   <= cfg_data[RCNT_W-1:0];
        REG_INDEX_OFFSET:   index_offset   <= cfg_data[0];
        REG_CLIP_ENABLE:    clip_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, table access and divider requests
  always_comb begin
    state_next  = state;
    rd_addr     = '0;
    mem_we      = 1'b0;
    div_req     = '0;
    case (state)
      S_IDLE: begin
        // read of the first boundary goes out with the transfer
        if (in_xfer) begin
          if (req.req_type == REQ_CLASSIFY) begin
            state_next = trivial ? S_DONE : S_RD_HI;
          end else begin
            mem_we = slot_ok;
          end
        end
      end
      S_RD_HI: begin
        rd_addr    = AW'(nb - CW'(1));
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        rd_addr    = '0;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        rd_addr = AW'(ptr);
        if (ptr == nb) begin
          state_next = S_INDEX;
        end
      end
      S_INDEX: begin
        state_next = S_STRETCH;
      end
      S_STRETCH: begin
        if (stretch_div) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NW'(ncol_m1) * DIV_NW'(unsigned'(idx));
          div_req.den   = DIV_DW'(region_count - RCNT_W'(1));
          state_next    = S_DIV_WAIT1;
        end else begin
          state_next = S_LIMIT;
        end
      end
      S_DIV_WAIT1: begin
        if (div_rsp.done) begin
          state_next = S_LIMIT;
        end
      end
      S_LIMIT: begin
        state_next = S_NORM;
      end
      S_NORM: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'({idx_abs, {FRAC_W{1'b0}}});
        div_req.den   = DIV_DW'(ncol_m1);
        state_next    = S_DIV_WAIT2;
      end
      S_DIV_WAIT2: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sample <= req.value;
        if (in_xfer && req.req_type == REQ_CLASSIFY && trivial) begin
          res_ci   <= '0;
          res_norm <= '0;
        end
      end
      S_RD_HI: begin
        lo <= $signed(rdata);
      end
      S_CLAMP: begin
        hi  <= $signed(rdata);
        vc  <= vc_next;
        ptr <= CW'(1);
        cnt <= '0;
      end
      S_SCAN: begin
        // data of the read issued in the previous cycle
        if ($signed(rdata) <= vc) begin
          cnt <= cnt + CW'(1);
        end
        ptr <= ptr + CW'(1);
      end
      S_INDEX: begin
        idx <= $signed(CI_W'(cnt) - CI_W'(1) + CI_W'(index_offset));
      end
      S_STRETCH: begin
        if (!stretch_div && single_region) begin
          idx <= $signed(CI_W'(ncol_m1 >> 1));
        end
      end
      S_DIV_WAIT1: begin
        // early saturation; the range checks below override it where they apply
        if (div_rsp.done) begin
          if (div_rsp.quo > DIV_NW'(ncol_m1)) begin
            idx <= $signed(CI_W'(ncol_m1));
          end else begin
            idx <= $signed(CI_W'(div_rsp.quo));
          end
        end
      end
      S_LIMIT: begin
        if (vc < lo) begin
          idx <= '1;
        end else if (vc > hi) begin
          idx <= clip_enable ? $signed(CI_W'(ncol_m1)) : $signed(CI_W'(color_count));
        end else if (idx > $signed(CI_W'(ncol_m1))) begin
          idx <= $signed(CI_W'(ncol_m1));
        end
      end
      S_NORM: begin
        neg    <= idx[CI_W-1];
        res_ci <= idx;
      end
      S_DIV_WAIT2: begin
        // truncation toward zero: divide the magnitude, then restore the sign
        if (div_rsp.done) begin
          res_norm <= neg ? $signed(-quo_low) : $signed(quo_low);
        end
      end
      default: ;
    endcase
  end

  // output register: loads when empty or when its result transfers this cycle
  assign out_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_ci   <= res_ci;
      out_norm <= res_norm;
    end
  end

  assign res.valid       = out_valid;
  assign res.color_index = out_ci;
  assign res.normalized  = out_norm;

  bbci_table_mem #(
    .DEPTH (MAX_BOUNDARIES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(req.slot)),
    .wdata (req.value),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  bbci_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

`default_nettype wire

// ===== dv/bbci_checker.sv =====
// checker for the boundary color index block: predicts every classify result and compares
`timescale 1ns / 1ps

module bbci_checker
  import bbci_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  bbci_req_if                        req,
  bbci_res_if                        res,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         errors,
  output int                         pending,
  output int                         results
);

  localparam int    REPORT_LIMIT = 10;
  localparam longint Q16_ONE     = longint'(1) << FRAC_W;

  typedef struct packed {
    logic signed [CI_W-1:0]   color_index;
    logic signed [NORM_W-1:0] normalized;
  } color_res_t;

  // shadow of the boundary table and the configuration registers
  logic signed [VAL_W-1:0] bounds [BBCI_MAX_BOUNDARIES];
  logic [BCNT_W-1:0]       bound_count;
  logic [CCNT_W-1:0]       color_count;
  logic [RCNT_W-1:0]       region_count;
  logic                    index_offset;
  logic                    clip_on;

  color_res_t expected_colors [$];
  color_res_t want;

  function automatic color_res_t predict_color(input logic signed [VAL_W-1:0] sample);
    color_res_t r;
    int     nb;
    int     hits;
    int     i;
    longint lo, hi, vc, idx, ncol, nreg, norm;
    r    = '0;
    nb   = (bound_count > BBCI_MAX_BOUNDARIES) ? BBCI_MAX_BOUNDARIES : int'(bound_count);
    ncol = longint'(color_count);
    nreg = longint'(region_count);
    if (nb < 2 || ncol < 2) begin
      return r;
    end
    lo = bounds[0];
    hi = bounds[nb-1];
    vc = sample;
    if (clip_on) begin
      if (vc < lo) begin
        vc = lo;
      end else if (vc > hi) begin
        vc = hi;
      end
    end
    hits = 0;
    for (i = 0; i < nb; i++) begin
      if (longint'(bounds[i]) <= vc) begin
        hits++;
      end
    end
    idx = longint'(hits) - 1 + longint'(index_offset);
    // stretch the bin index over the color range
    if (ncol > nreg && nreg > 0) begin
      if (nreg == 1) begin
        if (idx == 0) begin
          idx = (ncol - 1) / 2;
        end
      end else if (idx >= 0) begin
        idx = ((ncol - 1) * idx) / (nreg - 1);
      end
    end
    if (vc < lo) begin
      idx = -1;
    end else if (vc > hi) begin
      idx = clip_on ? ncol - 1 : ncol;
    end else begin
      if (idx > ncol - 1) begin
        idx = ncol - 1;
      end
      if (idx < -1) begin
        idx = -1;
      end
    end
    norm = (idx * Q16_ONE) / (ncol - 1);
    r.color_index = CI_W'(idx);
    r.normalized  = NORM_W'(norm);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      bound_count  = '0;
      color_count  = '0;
      region_count = '0;
      index_offset = 1'b0;
      clip_on      = 1'b0;
      expected_colors.delete();
      errors  = 0;
      pending = 0;
      results = 0;
    end else begin
      if (res.valid && res.ready) begin
        results++;
        if (expected_colors.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("unexpected color result: index %0d norm %0d",
                     res.color_index, res.normalized);
          end
        end else begin
          want = expected_colors.pop_front();
          if (res.color_index !== want.color_index || res.normalized !== want.normalized) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("color result %0d: expected index %0d norm %0d, got index %0d norm %0d",
                       results, want.color_index, want.normalized,
                       res.color_index, res.normalized);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_CLASSIFY) begin
          expected_colors = {expected_colors, predict_color(req.value)};
        end else if (req.slot < BBCI_MAX_BOUNDARIES) begin
          bounds[req.slot] = req.value;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BOUNDARY_COUNT: bound_count  = cfg_data[BCNT_W-1:0];
          REG_COLOR_COUNT:    color_count  = cfg_data[CCNT_W-1:0];
          REG_REGION_COUNT:   region_count = cfg_data[RCNT_W-1:0];
          REG_INDEX_OFFSET:   index_offset = cfg_data[0];
          REG_CLIP_ENABLE:    clip_on      = cfg_data[0];
          default: ;
        endcase
      end
      pending = expected_colors.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// testbench top: clock, reset, stimulus and verdict for the boundary color index block
`timescale 1ns / 1ps

module testbench;
  import bbci_pkg::*;

  localparam int ITEM_TARGET   = 1100;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int IDLE_PCT      = 22;
  localparam int SETTLE_CYCLES = 8;   // a table write finishes at its transfer edge
  localparam int TAIL_CYCLES   = 80;
  localparam logic [CFG_IDX_W-1:0]    REG_SPARE_LO = 3'd5;  // first index past the register map
  localparam logic signed [VAL_W-1:0] VAL_MIN      = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX      = 32'sh7FFF_FFFF;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int pending;
  int results;
  int cycle_count;
  int n_writes;
  int n_classifies;
  int n_settings;
  bit calm;  // no idling on either side while set

  // copy of the table as written, used only to aim samples at the boundaries
  logic signed [VAL_W-1:0] shadow [BBCI_MAX_BOUNDARIES];

  bbci_req_if req_ch ();
  bbci_res_if res_ch ();

  boundary_bin_color_index dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bbci_checker color_check (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .results   (results)
  );

  // 20 ns clock, first rising edge at 10 ns
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: random back-pressure, none during the calm stretch
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("boundary_bin_color_index: mismatch");
    $finish;
  end

  // one request transfer; valid stays up when the next item follows at once
  task automatic send_item(input req_kind_t kind, input logic [SLOT_W-1:0] s,
                           input logic signed [VAL_W-1:0] v);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.slot     <= s;
    req_ch.value    <= v;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic write_slot(input int s, input logic signed [VAL_W-1:0] v);
    send_item(REQ_WRITE, SLOT_W'(s), v);
    shadow[s] = v;
    n_writes++;
  endtask

  // slot bits are don't-care on a classify, so they get random values
  task automatic classify(input logic signed [VAL_W-1:0] v);
    send_item(REQ_CLASSIFY, SLOT_W'($urandom), v);
    n_classifies++;
  endtask

  // let every expected result come back before touching the registers
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic set_regs(input int bc, input int cc, input int rc, input int off,
                          input int clip);
    write_reg(REG_BOUNDARY_COUNT, CFG_DATA_W'(bc));
    write_reg(REG_COLOR_COUNT, CFG_DATA_W'(cc));
    write_reg(REG_REGION_COUNT, CFG_DATA_W'(rc));
    write_reg(REG_INDEX_OFFSET, CFG_DATA_W'(off));
    write_reg(REG_CLIP_ENABLE, CFG_DATA_W'(clip));
    // now and then poke an index past the register map, which must be ignored
    if ($urandom_range(0, 3) == 0) begin
      write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // fill slots 0..n-1, ascending with duplicates, or scrambled
  task automatic load_table(input int n, input bit ordered);
    longint      v;
    int unsigned spread;
    int          i;
    v      = longint'($signed($urandom)) >>> $urandom_range(1, 10);
    spread = 1 << $urandom_range(0, 24);
    for (i = 0; i < n; i++) begin
      if (!ordered) begin
        write_slot(i, $urandom);
      end else begin
        if (v > VAL_MAX) begin
          v = VAL_MAX;
        end
        write_slot(i, VAL_W'(v));
        if ($urandom_range(0, 4) != 0) begin
          v += longint'($urandom_range(1, spread));
        end
      end
    end
    // full-scale end points every so often
    if (ordered && n >= 2 && $urandom_range(0, 5) == 0) begin
      write_slot(0, VAL_MIN);
      write_slot(n - 1, VAL_MAX);
    end
  endtask

  // samples cluster on the boundaries, inside the range and just outside it, with some random and full-scale values
  function automatic logic signed [VAL_W-1:0] pick_sample(input int n);
    longint lo, hi, span, s;
    if (n == 0) begin
      return $urandom;
    end
    lo = shadow[0];
    hi = shadow[n-1];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = longint'(shadow[$urandom_range(0, n - 1)]) + int'($urandom_range(0, 2)) - 1;
      4, 5, 6: begin
        span = hi - lo;
        s = (span <= 0) ? lo : lo + longint'($urandom) % (span + 1);
      end
      7: s = longint'($signed($urandom));
      8: s = $urandom_range(0, 1) ? longint'(VAL_MAX) : longint'(VAL_MIN);
      default: s = $urandom_range(0, 1) ? hi + longint'($urandom_range(1, 65536))
                                        : lo - longint'($urandom_range(1, 65536));
    endcase
    return VAL_W'(s);
  endfunction

  initial begin
    int bc, cc, rc, n, k, nitems, phase, base;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_BOUNDARY_COUNT;
    cfg_data        <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_WRITE;
    req_ch.slot     <= '0;
    req_ch.value    <= '0;
    calm         = 1'b0;
    n_writes     = 0;
    n_classifies = 0;
    n_settings   = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers still at reset: too few boundaries and colors, both outputs zero
    classify(32'sh0001_0000);

    // table: -3.0, 0.0, 2.0, near full scale
    write_slot(0, -32'sh0003_0000);
    write_slot(1, 32'sh0000_0000);
    write_slot(2, 32'sh0002_0000);
    write_slot(3, 32'sh7FFF_0000);

    // 256 colors over 5 regions with a lower extension region, no clipping
    drain();
    set_regs(4, 256, 5, 1, 0);
    classify(VAL_MIN);          // below range
    classify(-32'sh0003_0000);  // exactly on the first boundary
    classify(32'sh0001_0000);   // inside a middle bin
    classify(32'sh7FFF_0000);   // exactly on the last boundary
    classify(VAL_MAX);          // above range, one past the top color

    // same with clipping: both extremes land on the end boundaries
    drain();
    set_regs(4, 256, 5, 1, 1);
    classify(VAL_MIN);
    classify(VAL_MAX);

    // single region: index zero moves to the middle color
    drain();
    set_regs(4, 9, 1, 0, 0);
    classify(-32'sh0000_0001);
    classify(32'sh0002_0000);

    // too few colors for the index: saturates to the top color
    drain();
    set_regs(4, 3, 0, 1, 0);
    classify(32'sh7FFF_0000);

    // one color only
    drain();
    set_regs(4, 1, 0, 0, 0);
    classify(32'sh0000_0000);

    // two colors, table made unsorted, with and without clipping
    drain();
    set_regs(2, 2, 0, 1, 0);
    write_slot(1, -32'sh0005_0000);
    classify(-32'sh0004_0000);
    drain();
    set_regs(2, 2, 0, 1, 1);
    classify(-32'sh0004_0000);

    // random phases: each picks a setting, loads a fresh table, then mostly classifies
    base  = n_writes + n_classifies;
    phase = 0;
    while (n_writes + n_classifies - base < ITEM_TARGET) begin
      drain();
      calm = (phase == 6 || phase == 7);
      case ($urandom_range(0, 9))
        0:       bc = $urandom_range(0, 1);
        1:       bc = BBCI_MAX_BOUNDARIES;
        2:       bc = $urandom_range(BBCI_MAX_BOUNDARIES + 1, 31);  // saturates
        default: bc = $urandom_range(2, BBCI_MAX_BOUNDARIES);
      endcase
      case ($urandom_range(0, 9))
        0:       cc = $urandom_range(0, 1);
        1:       cc = 256;
        2:       cc = $urandom_range(257, 511);
        3:       cc = 2;
        default: cc = $urandom_range(2, 255);
      endcase
      case ($urandom_range(0, 9))
        0:       rc = 0;
        1:       rc = 1;
        2:       rc = $urandom_range(19, 31);
        default: rc = $urandom_range(2, 18);
      endcase
      set_regs(bc, cc, rc, $urandom_range(0, 1), $urandom_range(0, 1));
      n = (bc > BBCI_MAX_BOUNDARIES) ? BBCI_MAX_BOUNDARIES : bc;
      load_table(n, $urandom_range(0, 9) != 0);
      nitems = $urandom_range(25, 50);
      for (k = 0; k < nitems; k++) begin
        // stray table writes, some of them inside the active range
        if ($urandom_range(0, 99) < 12) begin
          write_slot($urandom_range(0, BBCI_MAX_BOUNDARIES - 1), $urandom);
        end else begin
          classify(pick_sample(n));
        end
      end
      phase++;
    end
    calm = 1'b0;

    // wait for the last results, then a tail for anything unexpected
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d table writes and %0d classify requests under %0d register settings",
             n_writes, n_classifies, n_settings);
    $display("%0d color results compared, %0d errors", results, errors);
    if (errors == 0 && pending == 0) begin
      $display("boundary_bin_color_index: match");
    end else begin
      $display("boundary_bin_color_index: mismatch");
    end
    $finish;
  end

endmodule

// ===== boundary_bin_color_index.f =====
rtl/bbci_pkg.sv
rtl/bbci_if.sv
rtl/bbci_table_mem.sv
rtl/bbci_divider.sv
rtl/boundary_bin_color_index.sv
dv/bbci_checker.sv
dv/testbench.sv
